// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the keypad block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/kvdr_pkg.sv
// Types, codes and the default key table of the keypad debounce/remap block.
// Depends on nothing; imported by the top level and the checker.
package kvdr_pkg;

  typedef enum logic [2:0] {
    CMD_POLL   = 3'd0,
    CMD_TICK   = 3'd1,
    CMD_CONFIG = 3'd2,
    CMD_EXIT   = 3'd3,
    CMD_REMAP  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_WRITE     = 3'd0,
    MODE_SET       = 3'd1,
    MODE_DEB_SET   = 3'd2,
    MODE_DEB_WRITE = 3'd3,
    MODE_AWAIT     = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_CHAR      = 3'd1,
    EV_REMAP     = 3'd2,
    EV_ENTER_SET = 3'd3,
    EV_EXIT_SET  = 3'd4,
    EV_AWAIT     = 3'd5
  } event_e;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_IDLE     = 1'b1;

  localparam logic [7:0]  DEBOUNCE_RESET = 8'd30;
  localparam logic [15:0] IDLE_RESET     = 16'd1500;

  // Power-up character for each scan code; unlisted codes map to zero.
  function automatic logic [7:0] dflt_char(input logic [7:0] k);
    logic [7:0] c;
    case (k)
      8'd3:    c = 8'h30;
      8'd10:   c = 8'h39;
      8'd11:   c = 8'h38;
      8'd12:   c = 8'h37;
      8'd13:   c = 8'h34;
      8'd14:   c = 8'h33;
      8'd15:   c = 8'h32;
      8'd16:   c = 8'h31;
      8'd28:   c = 8'h36;
      8'd29:   c = 8'h35;
      8'd44:   c = 8'h4E;
      8'd45:   c = 8'h42;
      8'd51:   c = 8'h3D;
      8'd52:   c = 8'h0A;
      8'd58:   c = 8'h2E;
      8'd59:   c = 8'h2C;
      8'd60:   c = 8'h4D;
      8'd61:   c = 8'h56;
      8'd62:   c = 8'h43;
      8'd63:   c = 8'h58;
      8'd64:   c = 8'h5A;
      8'd70:   c = 8'h20;
      8'd76:   c = 8'h48;
      8'd77:   c = 8'h47;
      8'd83:   c = 8'h3B;
      8'd90:   c = 8'h4C;
      8'd91:   c = 8'h4B;
      8'd92:   c = 8'h4A;
      8'd93:   c = 8'h46;
      8'd94:   c = 8'h44;
      8'd95:   c = 8'h53;
      8'd96:   c = 8'h41;
      8'd108:  c = 8'h59;
      8'd109:  c = 8'h54;
      8'd112:  c = 8'h09;
      8'd115:  c = 8'h50;
      8'd122:  c = 8'h4F;
      8'd123:  c = 8'h49;
      8'd124:  c = 8'h55;
      8'd125:  c = 8'h52;
      8'd126:  c = 8'h45;
      8'd127:  c = 8'h57;
      8'd128:  c = 8'h51;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/kvdr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module kvdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/keypad_vote_debounce_remap.sv
// Keypad debounce by majority vote, with a remappable key-code table.
// Depends on kvdr_pkg and kvdr_ram.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tuser: command; tdata: key_code, new_char
//   m_axis    out  m_axis_tvalid/tready       tuser: event_res;
//                                             tdata: out_char, held_key_out, mode
//   cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// Every transaction is handled at its accepting edge: state updates there
// and the result lands in the output register at that same edge.
// A new transaction is taken each cycle while the output register is empty
// or being drained, so the sustained rate is one item per clock.
// The key map read is registered and always addresses the held key, so a
// character is ready by the time the window that uses it closes.
// Reset clears the mode, counters and per-entry valid bits; no clearing pass.
module keypad_vote_debounce_remap #(
  parameter int KEY_CODES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] key_code, [15:8] new_char
  input  logic [2:0]  s_axis_tuser,   // [2:0] command
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_char, [15:8] held_key_out,
                                      // [18:16] mode, [23:19] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  import kvdr_pkg::*;

  localparam int         AddrW    = $clog2(KEY_CODES);
  localparam logic [8:0] KeyLimit = 9'(KEY_CODES);

  // Configuration registers.
  logic [7:0]  deb_ticks_q;
  logic [15:0] idle_ticks_q;

  // Block state.
  mode_e              mode_q, mode_d;
  logic [7:0]         held_key_q, held_key_d;
  logic signed [7:0]  vote_q, vote_d;
  logic [15:0]        tick_q, tick_d;
  logic [KEY_CODES-1:0] map_valid_q;
  logic               valid_rd_q;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic [7:0]  out_held_q;
  mode_e       out_mode_q;
  event_e      out_event_q;

  logic        in_acc;
  cmd_e        cmd;
  logic [7:0]  key;
  logic [7:0]  new_char;
  logic        key_ok;
  logic [15:0] tick_inc;
  logic [7:0]  ram_rdata;
  logic [7:0]  map_char;
  logic        map_we;
  event_e      event_d;
  logic [7:0]  char_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign cmd      = cmd_e'(s_axis_tuser);
  assign key      = s_axis_tdata[7:0];
  assign new_char = s_axis_tdata[15:8];

  // Codes past the map size never become the held key.
  assign key_ok   = (key != 8'd0) && ({1'b0, key} < KeyLimit);
  assign tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;

  // Written entries come from the RAM; untouched ones keep the power-up table.
  assign map_char = valid_rd_q ? ram_rdata : dflt_char(held_key_q);

  always_comb begin
    mode_d     = mode_q;
    held_key_d = held_key_q;
    vote_d     = vote_q;
    tick_d     = tick_q;
    event_d    = EV_NONE;
    char_d     = 8'd0;
    map_we     = 1'b0;
    if (in_acc) begin
      case (cmd)
        CMD_POLL: begin
          if (mode_q == MODE_WRITE || mode_q == MODE_SET) begin
            // Start a debounce window on any valid press.
            if (key_ok) begin
              held_key_d = key;
              vote_d     = 8'sd0;
              tick_d     = 16'd0;
              mode_d     = (mode_q == MODE_WRITE) ? MODE_DEB_WRITE : MODE_DEB_SET;
            end
          end else if (mode_q == MODE_DEB_WRITE || mode_q == MODE_DEB_SET) begin
            // Vote, saturating at both ends.
            if (key == held_key_q) begin
              if (vote_q != 8'sd127) vote_d = vote_q + 8'sd1;
            end else begin
              if (vote_q != -8'sd128) vote_d = vote_q - 8'sd1;
            end
          end
        end
        CMD_TICK: begin
          if (mode_q == MODE_DEB_WRITE || mode_q == MODE_DEB_SET) begin
            tick_d = tick_inc;
            if (tick_inc > {8'd0, deb_ticks_q}) begin
              // Window closes: judge the vote.
              vote_d = 8'sd0;
              tick_d = 16'd0;
              if (mode_q == MODE_DEB_WRITE) begin
                mode_d = MODE_WRITE;
                if (vote_q > 8'sd0) begin
                  event_d = EV_CHAR;
                  char_d  = map_char;
                end
              end else if (vote_q > 8'sd0) begin
                mode_d  = MODE_AWAIT;
                event_d = EV_AWAIT;
              end else begin
                mode_d = MODE_SET;
              end
            end
          end else if (mode_q == MODE_SET) begin
            tick_d = tick_inc;
            if (tick_inc > idle_ticks_q) begin
              tick_d  = 16'd0;
              mode_d  = MODE_WRITE;
              event_d = EV_EXIT_SET;
            end
          end
        end
        CMD_CONFIG: begin
          if (mode_q == MODE_WRITE) begin
            mode_d  = MODE_SET;
            tick_d  = 16'd0;
            event_d = EV_ENTER_SET;
          end
        end
        CMD_EXIT: begin
          // Abandon a pending remap too.
          if (mode_q == MODE_SET || mode_q == MODE_AWAIT) begin
            mode_d  = MODE_WRITE;
            tick_d  = 16'd0;
            event_d = EV_EXIT_SET;
          end
        end
        CMD_REMAP: begin
          if (mode_q == MODE_AWAIT) begin
            map_we  = 1'b1;
            char_d  = new_char;
            mode_d  = MODE_SET;
            tick_d  = 16'd0;
            event_d = EV_REMAP;
          end
        end
        default: begin
          // Unknown command: no state change, reported as EV_NONE.
        end
      endcase
    end
  end

  // Key map storage; the read side tracks the next held key.
  kvdr_ram #(
    .WIDTH (8),
    .DEPTH (KEY_CODES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (held_key_q[AddrW-1:0]),
    .wdata_i (new_char),
    .raddr_i (held_key_d[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= DEBOUNCE_RESET;
      idle_ticks_q <= IDLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DEBOUNCE: deb_ticks_q  <= cfg_data_i[7:0];
        REG_IDLE:     idle_ticks_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Block state and map valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_WRITE;
      held_key_q  <= 8'd0;
      vote_q      <= 8'sd0;
      tick_q      <= 16'd0;
      map_valid_q <= '0;
      valid_rd_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      held_key_q <= held_key_d;
      vote_q     <= vote_d;
      tick_q     <= tick_d;
      if (map_we) begin
        map_valid_q[held_key_q[AddrW-1:0]] <= 1'b1;
      end
      // Read alongside the RAM so both reflect the same writes.
      valid_rd_q <= map_valid_q[held_key_d[AddrW-1:0]];
    end
  end

  // Output register: load on accept, drop once the transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_event_q <= event_d;
      out_char_q  <= char_d;
      out_held_q  <= held_key_d;
      out_mode_q  <= mode_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_event_q;
  assign m_axis_tdata  = {5'd0, out_mode_q, out_held_q, out_char_q};

endmodule

// File: rtl/kvdr_checker.sv
// Port-level checks for the keypad debounce/remap block, bound to its top level.
// Depends on kvdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvdr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        cfg_index_i,
  input logic [15:0] cfg_data_i
);

  import kvdr_pkg::*;

  // A stalled result holds.
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // An emitted character always leaves the block in write mode.
  `ASSERT_IMPL(a_char_mode, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == EV_CHAR, m_axis_tdata[18:16] == MODE_WRITE)

  // Remap and entering set both leave the block in set mode.
  `ASSERT_IMPL(a_set_mode, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == EV_REMAP || m_axis_tuser == EV_ENTER_SET), m_axis_tdata[18:16] == MODE_SET)

  // Awaiting a character means the await mode.
  `ASSERT_IMPL(a_await_mode, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == EV_AWAIT, m_axis_tdata[18:16] == MODE_AWAIT)

  // The character field is zero for every event that carries none.
  `ASSERT_IMPL(a_char_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != EV_CHAR && m_axis_tuser != EV_REMAP, m_axis_tdata[7:0] == 8'd0)

endmodule

bind keypad_vote_debounce_remap kvdr_checker u_kvdr_checker (.*);
